FILE: rtl/kmer_merge_count_correlation_assert.svh
// assertion macros shared by the kmer merge count correlation modules
`ifndef KMER_MERGE_COUNT_CORRELATION_ASSERT_SVH
`define KMER_MERGE_COUNT_CORRELATION_ASSERT_SVH

`ifndef NO_ASSERTIONS
// condition must hold at every clock edge outside reset
`define KMC_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);
// condition in one cycle implies a condition in the next cycle
`define KMC_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);
`else
`define KMC_ASSERT(lbl, expr, msg)
`define KMC_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

FILE: rtl/kmc_pkg.sv
package kmc_pkg;

    localparam int KEY_BITS_DEF = 128;
    localparam int CNT_W        = 16;
    localparam int CFG_W        = 15;
    localparam int ACC_W        = 64;
    localparam int SQ_W         = 2 * CNT_W;
    localparam int IN_TDATA_W   = 144;
    localparam int OUT_TDATA_W  = 392;

    localparam logic [CFG_W-1:0] CFG_LOW_RST  = CFG_W'(1);
    localparam logic [CFG_W-1:0] COUNT_LIMIT  = 15'h7fff;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_FIRST_LOW   = 2'd0,
        CFG_FIRST_HIGH  = 2'd1,
        CFG_SECOND_LOW  = 2'd2,
        CFG_SECOND_HIGH = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] first_low;
        logic [CFG_W-1:0] first_high;
        logic [CFG_W-1:0] second_low;
        logic [CFG_W-1:0] second_high;
    } cfg_t;

    // per-item increments handed from the join stage to the accumulators
    typedef struct packed {
        logic             fin;
        logic [1:0]       total;
        logic [CNT_W-1:0] first;
        logic [SQ_W-1:0]  sq_first;
        logic [CNT_W-1:0] second;
        logic [SQ_W-1:0]  sq_second;
        logic [SQ_W-1:0]  product;
    } inc_t;

    function automatic logic in_range(logic [CNT_W-1:0] c, logic [CFG_W-1:0] lo,
                                      logic [CFG_W-1:0] hi);
        in_range = (c >= {1'b0, lo}) && (c <= {1'b0, hi});
    endfunction

    // saturating add, carry-out bit on top flags saturation
    function automatic logic [ACC_W:0] sat_add(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[ACC_W] ? {1'b1, {ACC_W{1'b1}}} : s;
    endfunction

endpackage

FILE: rtl/kmc_join.sv
module kmc_join import kmc_pkg::*; #(
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_fin,
    input  logic                in_second,
    input  logic [KEY_BITS-1:0] in_key,
    input  logic [CNT_W-1:0]    in_occ,
    output logic                inc_valid,
    input  logic                inc_ready,
    output inc_t                inc
);

    `include "kmer_merge_count_correlation_assert.svh"

    logic                pend_v_reg;
    logic [KEY_BITS-1:0] pend_key_reg;
    logic [CNT_W-1:0]    pend_occ_reg;
    logic                inc_v_reg;
    inc_t                inc_reg;
    inc_t                inc_next;
    logic                take;
    logic                match;
    logic                flush;
    logic                pair;
    logic                sec_single;
    logic                add_first;
    logic                add_second;
    logic                add_pair;

    assign in_ready  = !inc_v_reg || inc_ready;
    assign take      = in_valid && in_ready;
    assign inc_valid = inc_v_reg;
    assign inc       = inc_reg;

    // classify the transaction against the pending first-table entry
    always_comb begin
        match      = pend_v_reg && (pend_key_reg == in_key);
        flush      = pend_v_reg && (in_fin || !in_second || !match);
        pair       = !in_fin && in_second && match;
        sec_single = !in_fin && in_second && !match;
        add_pair   = pair && (in_range(pend_occ_reg, cfg.first_low, cfg.first_high) ||
                              in_range(in_occ, cfg.second_low, cfg.second_high));
        add_first  = flush && in_range(pend_occ_reg, cfg.first_low, cfg.first_high);
        add_second = sec_single && in_range(in_occ, cfg.second_low, cfg.second_high);
    end

    // increments: counts, squares and product
    always_comb begin
        inc_next.fin       = in_fin;
        inc_next.total     = 2'(add_first) + 2'(add_second) + 2'(add_pair);
        inc_next.first     = (add_first || add_pair) ? pend_occ_reg : '0;
        inc_next.sq_first  = (add_first || add_pair) ? pend_occ_reg * pend_occ_reg : '0;
        inc_next.second    = (add_second || add_pair) ? in_occ : '0;
        inc_next.sq_second = (add_second || add_pair) ? in_occ * in_occ : '0;
        inc_next.product   = add_pair ? pend_occ_reg * in_occ : '0;
    end

    // pending entry and increment register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_v_reg   <= 1'b0;
            pend_key_reg <= '0;
            pend_occ_reg <= '0;
            inc_v_reg    <= 1'b0;
        end else begin
            if (in_ready) begin
                inc_v_reg <= in_valid;
            end
            if (take) begin
                pend_v_reg <= !in_fin && !in_second;
                if (!in_fin && !in_second) begin
                    pend_key_reg <= in_key;
                    pend_occ_reg <= in_occ;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            inc_reg <= inc_next;
        end
    end

    `KMC_ASSERT_NEXT(a_pend_set, take && !in_fin && !in_second, pend_v_reg, "pending not set")
    `KMC_ASSERT_NEXT(a_pend_clr, take && (in_fin || in_second), !pend_v_reg, "pending not cleared")

endmodule

FILE: rtl/kmc_accum.sv
module kmc_accum import kmc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   inc_valid,
    output logic                   inc_ready,
    input  inc_t                   inc,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [OUT_TDATA_W-1:0] m_data
);

    `include "kmer_merge_count_correlation_assert.svh"

    logic [ACC_W-1:0] total_reg, first_reg, second_reg;
    logic [ACC_W-1:0] sq_first_reg, sq_second_reg, product_reg;
    logic             sat_reg;
    logic [ACC_W:0]   total_next, first_next, second_next;
    logic [ACC_W:0]   sq_first_next, sq_second_next, product_next;
    logic             sat_next;
    logic             out_v_reg;
    logic [OUT_TDATA_W-1:0] out_reg;
    logic             adv;

    // a finish waits only while the output slot holds an untaken result
    assign adv       = inc_valid && (!inc.fin || !out_v_reg || m_ready);
    assign inc_ready = adv;
    assign m_valid   = out_v_reg;
    assign m_data    = out_reg;

    // saturating sums
    always_comb begin
        total_next     = sat_add(total_reg, ACC_W'(inc.total));
        first_next     = sat_add(first_reg, ACC_W'(inc.first));
        second_next    = sat_add(second_reg, ACC_W'(inc.second));
        sq_first_next  = sat_add(sq_first_reg, ACC_W'(inc.sq_first));
        sq_second_next = sat_add(sq_second_reg, ACC_W'(inc.sq_second));
        product_next   = sat_add(product_reg, ACC_W'(inc.product));
        sat_next       = sat_reg || total_next[ACC_W] || first_next[ACC_W] ||
                         second_next[ACC_W] || sq_first_next[ACC_W] ||
                         sq_second_next[ACC_W] || product_next[ACC_W];
    end

    // accumulators and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg     <= '0;
            first_reg     <= '0;
            second_reg    <= '0;
            sq_first_reg  <= '0;
            sq_second_reg <= '0;
            product_reg   <= '0;
            sat_reg       <= 1'b0;
            out_v_reg     <= 1'b0;
        end else begin
            if (adv && inc.fin) begin
                total_reg     <= '0;
                first_reg     <= '0;
                second_reg    <= '0;
                sq_first_reg  <= '0;
                sq_second_reg <= '0;
                product_reg   <= '0;
                sat_reg       <= 1'b0;
                out_v_reg     <= 1'b1;
            end else begin
                if (adv) begin
                    total_reg     <= total_next[ACC_W-1:0];
                    first_reg     <= first_next[ACC_W-1:0];
                    second_reg    <= second_next[ACC_W-1:0];
                    sq_first_reg  <= sq_first_next[ACC_W-1:0];
                    sq_second_reg <= sq_second_next[ACC_W-1:0];
                    product_reg   <= product_next[ACC_W-1:0];
                    sat_reg       <= sat_next;
                end
                if (m_ready) begin
                    out_v_reg <= 1'b0;
                end
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (adv && inc.fin) begin
            out_reg <= {7'd0, sat_next, product_next[ACC_W-1:0],
                        sq_second_next[ACC_W-1:0], sq_first_next[ACC_W-1:0],
                        second_next[ACC_W-1:0], first_next[ACC_W-1:0],
                        total_next[ACC_W-1:0]};
        end
    end

    `KMC_ASSERT_NEXT(a_sat_sticky, adv && !inc.fin && sat_reg, sat_reg, "overflow flag lost")
    `KMC_ASSERT_NEXT(a_clear, adv && inc.fin, total_reg == '0 && !sat_reg, "sums not cleared")
    `KMC_ASSERT_NEXT(a_out_load, adv && inc.fin, out_v_reg, "result not presented")

endmodule

FILE: rtl/kmer_merge_count_correlation.sv
// a finish passes the input register and the join's increment register before m_tvalid
// rises; throughput: one transaction per cycle through the input register, the join
// stage with its pending entry and multipliers, and the saturating accumulators, but a
// finish waits in the accumulator stage only while a previous result is not yet taken
// reset: synchronous active-low aresetn clears the sums, the pending entry and the valids,
// and sets the count ranges to 1..32767
module kmer_merge_count_correlation import kmc_pkg::*; #(
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration writes
    input  logic                   cfg_wr_en,
    input  logic [1:0]             cfg_addr,
    input  logic [CFG_W-1:0]       cfg_wdata,
    // input transactions
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // key_upper, key_lower, occurrences
    input  logic [1:0]             s_tuser,   // finish, from_second
    // result transactions
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // pair_total, sum_first, sum_second, squares_first, squares_second, sum_product,
    // overflowed, zero fill
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    cfg_t                cfg_reg;
    logic                v1_reg;
    logic                fin1_reg;
    logic                sec1_reg;
    logic [KEY_BITS-1:0] key1_reg;
    logic [CNT_W-1:0]    occ1_reg;
    logic [127:0]        key_full;
    logic                join_ready;
    logic                inc_valid;
    logic                inc_ready;
    inc_t                inc;

    assign key_full = {s_tdata[63:0], s_tdata[127:64]};
    assign s_tready = !v1_reg || join_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_low   <= CFG_LOW_RST;
            cfg_reg.first_high  <= COUNT_LIMIT;
            cfg_reg.second_low  <= CFG_LOW_RST;
            cfg_reg.second_high <= COUNT_LIMIT;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_FIRST_LOW:   cfg_reg.first_low   <= cfg_wdata;
                CFG_FIRST_HIGH:  cfg_reg.first_high  <= cfg_wdata;
                CFG_SECOND_LOW:  cfg_reg.second_low  <= cfg_wdata;
                CFG_SECOND_HIGH: cfg_reg.second_high <= cfg_wdata;
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_tready) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            fin1_reg <= s_tuser[0];
            sec1_reg <= s_tuser[1];
            key1_reg <= key_full[KEY_BITS-1:0];
            occ1_reg <= s_tdata[143:128];
        end
    end

    kmc_join #(
        .KEY_BITS (KEY_BITS)
    ) u_join (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (v1_reg),
        .in_ready  (join_ready),
        .in_fin    (fin1_reg),
        .in_second (sec1_reg),
        .in_key    (key1_reg),
        .in_occ    (occ1_reg),
        .inc_valid (inc_valid),
        .inc_ready (inc_ready),
        .inc       (inc)
    );

    kmc_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .inc_valid (inc_valid),
        .inc_ready (inc_ready),
        .inc       (inc),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (m_tdata)
    );

endmodule

FILE: test/kmer_merge_count_correlation_tb.sv
module kmer_merge_count_correlation_tb;
    import kmc_pkg::*;

    localparam int LATENCY     = 3;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 120;

    typedef enum int {
        PACE_SLOW_SINK,
        PACE_SLOW_SOURCE,
        PACE_FULL_RATE
    } pace_t;

    // laid out like the low bits of m_tdata, first member on top
    typedef struct packed {
        logic        overflowed;
        logic [63:0] sum_product;
        logic [63:0] squares_second;
        logic [63:0] squares_first;
        logic [63:0] sum_second;
        logic [63:0] sum_first;
        logic [63:0] pair_total;
    } moments_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [1:0]             cfg_addr  = CFG_FIRST_LOW;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // key_upper, key_lower, occurrences
    logic [1:0]             s_tuser   = '0;   // finish, from_second
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // pair_total, sum_first, sum_second, squares_first, squares_second, sum_product,
    // overflowed, zero fill
    logic [OUT_TDATA_W-1:0] m_tdata;

    pace_t pace_mode   = PACE_SLOW_SINK;
    logic  holding     = 1'b0;
    int    mismatches  = 0;
    int    idle_cycles = 0;
    event  hold_start;

    // expected state of the join and the moment sums
    logic [CFG_W-1:0] first_lo, first_hi, second_lo, second_hi;
    logic             held_valid;
    logic [127:0]     held_key;
    logic [CNT_W-1:0] held_count;
    moments_t         running;
    moments_t         sums_due[$];

    always #10 aclk = ~aclk;

    kmer_merge_count_correlation dut (.*);

    function automatic int source_gap_pct();
        case (pace_mode)
            PACE_SLOW_SINK:   return 28;
            PACE_SLOW_SOURCE: return 60;
            default:          return 0;
        endcase
    endfunction

    function automatic int sink_stall_pct();
        case (pace_mode)
            PACE_SLOW_SINK:   return 60;
            PACE_SLOW_SOURCE: return 28;
            default:          return 0;
        endcase
    endfunction

    function automatic void reset_prediction();
        first_lo   = CFG_LOW_RST;
        first_hi   = COUNT_LIMIT;
        second_lo  = CFG_LOW_RST;
        second_hi  = COUNT_LIMIT;
        held_valid = 1'b0;
        held_key   = '0;
        held_count = '0;
        running    = '0;
    endfunction

    // 64-bit add that sticks at all ones and marks the overflow
    function automatic logic [63:0] add_clamped(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[64]) begin
            running.overflowed = 1'b1;
            return '1;
        end
        return s[63:0];
    endfunction

    function automatic logic count_in_window(logic [CNT_W-1:0] c, logic [CFG_W-1:0] lo,
                                             logic [CFG_W-1:0] hi);
        return (c >= {1'b0, lo}) && (c <= {1'b0, hi});
    endfunction

    function automatic logic [63:0] times(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
        return {48'b0, a} * {48'b0, b};
    endfunction

    // one k-mer from either or both tables; counted if any present count is in range
    function automatic void tally(logic has_first, logic [CNT_W-1:0] c,
                                  logic has_second, logic [CNT_W-1:0] d);
        logic ok;
        ok = (has_first && count_in_window(c, first_lo, first_hi)) ||
             (has_second && count_in_window(d, second_lo, second_hi));
        if (!ok)
            return;
        running.pair_total = add_clamped(running.pair_total, 64'd1);
        if (has_first) begin
            running.sum_first     = add_clamped(running.sum_first, {48'b0, c});
            running.squares_first = add_clamped(running.squares_first, times(c, c));
        end
        if (has_second) begin
            running.sum_second     = add_clamped(running.sum_second, {48'b0, d});
            running.squares_second = add_clamped(running.squares_second, times(d, d));
        end
        if (has_first && has_second)
            running.sum_product = add_clamped(running.sum_product, times(c, d));
    endfunction

    function automatic void flush_held();
        if (held_valid)
            tally(1'b1, held_count, 1'b0, '0);
        held_valid = 1'b0;
    endfunction

    // merge-join step for one accepted transaction
    function automatic void join_and_tally(logic finish, logic second, logic [127:0] key,
                                           logic [CNT_W-1:0] occ);
        if (finish) begin
            flush_held();
            sums_due.push_back(running);
            running = '0;
        end else if (!second) begin
            flush_held();
            held_valid = 1'b1;
            held_key   = key;
            held_count = occ;
        end else if (held_valid && held_key == key) begin
            tally(1'b1, held_count, 1'b1, occ);
            held_valid = 1'b0;
        end else begin
            flush_held();
            tally(1'b0, '0, 1'b1, occ);
        end
    endfunction

    function automatic logic [127:0] any_key();
        logic [127:0] k;
        k = {$urandom(), $urandom(), $urandom(), $urandom()};
        case ($urandom_range(0, 3))
            0:       k[127:64] = '0;
            1:       k[127:64] = '1;
            default: ;
        endcase
        return k;
    endfunction

    // counts cluster on the range edges, with some small and some anywhere
    function automatic logic [CNT_W-1:0] any_count(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi);
        case ($urandom_range(0, 6))
            0:       return {1'b0, lo};
            1:       return {1'b0, hi};
            2:       return {1'b0, lo} - 1'b1;
            3:       return {1'b0, hi} + 1'b1;
            4:       return CNT_W'($urandom_range(0, 40));
            default: return CNT_W'($urandom());
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    task automatic compare_sums(moments_t got, moments_t want);
        if (got.pair_total !== want.pair_total)
            report_mismatch("pair_total", got.pair_total, want.pair_total);
        if (got.sum_first !== want.sum_first)
            report_mismatch("sum_first", got.sum_first, want.sum_first);
        if (got.sum_second !== want.sum_second)
            report_mismatch("sum_second", got.sum_second, want.sum_second);
        if (got.squares_first !== want.squares_first)
            report_mismatch("squares_first", got.squares_first, want.squares_first);
        if (got.squares_second !== want.squares_second)
            report_mismatch("squares_second", got.squares_second, want.squares_second);
        if (got.sum_product !== want.sum_product)
            report_mismatch("sum_product", got.sum_product, want.sum_product);
        if (got.overflowed !== want.overflowed)
            report_mismatch("overflowed", 64'(got.overflowed), 64'(want.overflowed));
    endtask

    // result side: check each transaction, then pick the next ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (sums_due.size() == 0)
                report_mismatch("result with nothing expected", m_tdata[63:0], '0);
            else
                compare_sums(moments_t'(m_tdata[$bits(moments_t)-1:0]), sums_due.pop_front());
        end
        m_tready <= !holding && ($urandom_range(0, 99) >= sink_stall_pct());
    end

    // long receiver hold-off
    always begin
        @(hold_start);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        holding <= 1'b0;
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t timeout with %0d results outstanding", $realtime, sums_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_entry(logic finish, logic second, logic [127:0] key,
                              logic [CNT_W-1:0] occ);
        while ($urandom_range(0, 99) < source_gap_pct()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {second, finish};
        s_tdata  <= {occ, key[63:0], key[127:64]};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        join_and_tally(finish, second, key, occ);
    endtask

    // wait for every result, then let trailing entries clear the pipeline
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sums_due.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            CFG_FIRST_LOW:   first_lo  = value;
            CFG_FIRST_HIGH:  first_hi  = value;
            CFG_SECOND_LOW:  second_lo = value;
            CFG_SECOND_HIGH: second_hi = value;
            default: ;
        endcase
    endtask

    task automatic set_ranges(logic [CFG_W-1:0] fl, logic [CFG_W-1:0] fh,
                              logic [CFG_W-1:0] sl, logic [CFG_W-1:0] sh);
        write_reg(CFG_FIRST_LOW, fl);
        write_reg(CFG_FIRST_HIGH, fh);
        write_reg(CFG_SECOND_LOW, sl);
        write_reg(CFG_SECOND_HIGH, sh);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_join_cases();
        logic [127:0] k1, k2;
        k1 = 128'h0123_4567_89ab_cdef_0011_2233_4455_6677;
        k2 = 128'hfedc_ba98_7654_3210_8899_aabb_ccdd_eeff;
        // finish with nothing held, its other fields must be ignored
        send_entry(1'b1, 1'b1, '1, 16'hffff);
        // join on the all-zero key, second count at the top of the field
        send_entry(1'b0, 1'b0, '0, 16'd1);
        send_entry(1'b0, 1'b1, '0, 16'hffff);
        // two first-table entries on one key: the older goes out alone
        send_entry(1'b0, 1'b0, '1, 16'h7fff);
        send_entry(1'b0, 1'b0, '1, 16'h8000);
        // pair with both counts out of range
        send_entry(1'b0, 1'b1, '1, 16'h0000);
        // second-table entry with nothing held
        send_entry(1'b0, 1'b1, k2, 16'd5);
        // near misses in the top and bottom key bits
        send_entry(1'b0, 1'b0, k1, 16'd7);
        send_entry(1'b0, 1'b1, k1 ^ {1'b1, 127'b0}, 16'd9);
        send_entry(1'b0, 1'b0, k2, 16'd3);
        send_entry(1'b0, 1'b1, k2 ^ 128'd1, 16'd11);
        send_entry(1'b1, 1'b0, '0, '0);
        // zero count held into a finish
        send_entry(1'b0, 1'b0, k1, 16'd0);
        send_entry(1'b1, 1'b0, '0, '0);
        // in-range count held into a finish
        send_entry(1'b0, 1'b0, k2, 16'd100);
        send_entry(1'b1, 1'b1, '1, 16'hffff);
        drain();
    endtask

    task automatic test_range_edges();
        logic [127:0] k1, k2;
        k1 = 128'h8000_0000_0000_0001_8000_0000_0000_0001;
        k2 = 128'h0000_0000_0000_0000_ffff_ffff_ffff_fffe;
        // single-value ranges at both ends
        set_ranges(COUNT_LIMIT, COUNT_LIMIT, CFG_LOW_RST, CFG_LOW_RST);
        send_entry(1'b0, 1'b0, k1, 16'h7fff);
        send_entry(1'b0, 1'b1, k1, 16'd2);
        send_entry(1'b0, 1'b0, k1, 16'h7ffe);
        send_entry(1'b0, 1'b1, k2, 16'd1);
        send_entry(1'b0, 1'b1, k2, 16'd0);
        send_entry(1'b1, 1'b0, '0, '0);
        drain();
        // empty ranges in both tables
        set_ranges(15'd200, 15'd100, COUNT_LIMIT, CFG_LOW_RST);
        send_entry(1'b0, 1'b0, k2, 16'd150);
        send_entry(1'b0, 1'b1, k2, 16'd50);
        send_entry(1'b0, 1'b1, k1, 16'hffff);
        send_entry(1'b1, 1'b0, '0, '0);
        drain();
    endtask

    // receiver holds off while pairs and finishes keep coming at full rate
    task automatic test_full_backpressure();
        logic [127:0] key;
        pace_mode = PACE_FULL_RATE;
        -> hold_start;
        for (int i = 0; i < 12; i++) begin
            key = any_key();
            send_entry(1'b0, 1'b0, key, any_count(first_lo, first_hi));
            send_entry(1'b0, 1'b1, key, any_count(second_lo, second_hi));
            send_entry(1'b1, 1'b0, '0, '0);
        end
        drain();
    endtask

    task automatic test_random_phase(pace_t pace, logic [CFG_W-1:0] fl, logic [CFG_W-1:0] fh,
                                     logic [CFG_W-1:0] sl, logic [CFG_W-1:0] sh, int n_items);
        int           sent;
        int           pick;
        logic [127:0] key;
        logic [127:0] last_key;
        set_ranges(fl, fh, sl, sh);
        pace_mode = pace;
        sent      = 0;
        last_key  = any_key();
        key       = last_key;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 7) begin
                send_entry(1'b1, 1'($urandom()), any_key(), CNT_W'($urandom()));
                sent++;
            end else if (pick < 80) begin
                // one k-mer present in the first table, the second, or both
                key = any_key();
                case ($urandom_range(0, 2))
                    0: begin
                        send_entry(1'b0, 1'b0, key, any_count(first_lo, first_hi));
                        sent++;
                    end
                    1: begin
                        send_entry(1'b0, 1'b1, key, any_count(second_lo, second_hi));
                        sent++;
                    end
                    default: begin
                        send_entry(1'b0, 1'b0, key, any_count(first_lo, first_hi));
                        send_entry(1'b0, 1'b1, key, any_count(second_lo, second_hi));
                        sent += 2;
                    end
                endcase
            end else begin
                // out-of-order noise: repeated keys, one-bit near misses, either table
                case ($urandom_range(0, 2))
                    0:       key = last_key;
                    1:       key = last_key ^ (128'd1 << $urandom_range(0, 127));
                    default: key = any_key();
                endcase
                send_entry(1'b0, 1'($urandom()), key, CNT_W'($urandom()));
                sent++;
            end
            last_key = key;
        end
        send_entry(1'b1, 1'b0, '0, '0);
        drain();
    endtask

    initial begin
        reset_prediction();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_join_cases();
        test_range_edges();
        test_random_phase(PACE_SLOW_SINK, CFG_LOW_RST, COUNT_LIMIT, CFG_LOW_RST, COUNT_LIMIT,
                          320);
        test_random_phase(PACE_SLOW_SOURCE, 15'd10, 15'd200, 15'd5, 15'd5, 320);
        test_full_backpressure();
        test_random_phase(PACE_FULL_RATE, 15'd300, 15'd20, COUNT_LIMIT, COUNT_LIMIT, 320);
        test_random_phase(PACE_FULL_RATE, CFG_LOW_RST, CFG_LOW_RST, CFG_LOW_RST, 15'd60, 320);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/kmc_pkg.sv
rtl/kmc_join.sv
rtl/kmc_accum.sv
rtl/kmer_merge_count_correlation.sv
test/kmer_merge_count_correlation_tb.sv
